### design/assert_macros.svh
// Assertion macros shared by the PRESENT-80 encryption RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define PRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/prs80_pkg.sv
// Shared types, constants and round functions for PRESENT-80 encryption.
// No dependencies; used by the round cell and the top level.
`default_nettype none

package prs80_pkg;

  localparam int ROUND_COUNT = 31;
  localparam int ROUND_W     = 5;
  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 80;
  localparam int PERM_MOD    = 63;

  typedef logic [ROUND_W-1:0] rnd_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;

  typedef enum logic {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_idx_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic block_t sub_layer(input block_t s);
    block_t r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // Bit i moves to 16*i mod 63; bit 63 stays.
  function automatic block_t perm_layer(input block_t s);
    block_t r;
    int     dst;
    r = '0;
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      dst = (16 * i) % PERM_MOD;
      r[dst[5:0]] = s[i];
    end
    r[BLOCK_W-1] = s[BLOCK_W-1];
    return r;
  endfunction

  // Rotate left by 61, substitute the top nibble, fold in the round number.
  function automatic key_t key_next(input key_t k, input rnd_t rnd);
    key_t r;
    r = {k[18:0], k[79:19]};
    r[79:76] = SBOX[r[79:76]];
    r[19:15] = r[19:15] ^ rnd;
    return r;
  endfunction

endpackage

`default_nettype wire

### design/present80_block_encrypt.sv
// PRESENT-80 block encryption, one 64-bit block per cycle unless the output stalls.
// Input channel in_*: in_tdata carries the plaintext block (byte 0 in bits 7..0).
// Output channel out_*: out_tdata carries the ciphertext in the same byte order.
// Configuration: cfg_we writes cfg_wdata into key_low (index 0, key bits 63..0)
// or key_high (index 1, key bits 79..64, low 16 data bits kept). Write the key
// only while no block is in flight.
// Structure: a row of 31 round cells, each holding one block and its running
// key, followed by an output register that applies the final key whitening.
// Path: an accepted block passes every round cell, then the output register, before out_tvalid.
// Throughput: one block per cycle while out_tready stays high.
// Stall: the whole row and the output register advance together; when the
// output register holds an item and out_tready is low, the row freezes and
// in_tready drops until the item is taken. Items inside the row are kept.
// Reset: rst_n (synchronous, active low) empties the row and the output
// register and clears both key registers to zero.
`default_nettype none
`include "assert_macros.svh"

module present80_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] plaintext
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] ciphertext
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam int RC = prs80_pkg::ROUND_COUNT;

  logic              en;
  logic [63:0]       key_low_r;
  logic [15:0]       key_high_r;
  logic              valid_chain [RC+1];
  prs80_pkg::block_t state_chain [RC+1];
  prs80_pkg::key_t   key_chain   [RC+1];
  logic              out_valid_r;
  prs80_pkg::block_t out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (prs80_pkg::cfg_idx_t'(cfg_index))
        prs80_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        prs80_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Row advances whenever the output register is free or being drained.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign valid_chain[0] = in_tvalid;
  assign state_chain[0] = in_tdata;
  assign key_chain[0]   = {key_high_r, key_low_r};

  for (genvar i = 0; i < RC; i++) begin : g_round
    prs80_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .rnd     (prs80_pkg::rnd_t'(i + 1)),
      .valid_i (valid_chain[i]),
      .state_i (state_chain[i]),
      .key_i   (key_chain[i]),
      .valid_o (valid_chain[i+1]),
      .state_o (state_chain[i+1]),
      .key_o   (key_chain[i+1])
    );
  end

  assign out_data_nxt = state_chain[RC] ^ key_chain[RC][79:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_chain[RC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PRS_ASSERT_NEXT(a_accept_fills_first, in_tvalid && in_tready, valid_chain[1],
    "accepted item did not enter the first round cell")
  `PRS_ASSERT_NEXT(a_last_to_out, en, out_valid_r == $past(valid_chain[RC]),
    "output valid does not follow the last round cell")
  `PRS_ASSERT_NEXT(a_row_holds, !en, valid_chain[RC] == $past(valid_chain[RC]),
    "round row moved while the output was stalled")

endmodule

`default_nettype wire

### design/prs80_round_cell.sv
// One PRESENT-80 round: key add, S-box layer, bit permutation, key update.
// Depends on prs80_pkg for the round functions.
`default_nettype none

module prs80_round_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire prs80_pkg::rnd_t   rnd,
  input  wire logic              valid_i,
  input  wire prs80_pkg::block_t state_i,
  input  wire prs80_pkg::key_t   key_i,
  output logic                   valid_o,
  output prs80_pkg::block_t      state_o,
  output prs80_pkg::key_t        key_o
);

  logic              valid_r;
  prs80_pkg::block_t state_r, state_nxt;
  prs80_pkg::key_t   key_r, key_nxt;

  always_comb begin
    state_nxt = prs80_pkg::perm_layer(prs80_pkg::sub_layer(state_i ^ key_i[79:16]));
    key_nxt   = prs80_pkg::key_next(key_i, rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // Payload needs no reset; advance with the row.
  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign valid_o = valid_r;
  assign state_o = state_r;
  assign key_o   = key_r;

endmodule

`default_nettype wire
